// ----- rtl/core/prf_pkg.sv -----
// Shared types and constants of the packet ring FIFO.
package prf_pkg;

  localparam int unsigned HDR_BYTES = 4;

  typedef enum logic [2:0] {
    ACT_RAW_PUT  = 3'd0,
    ACT_PKT_PUT  = 3'd1,
    ACT_PUT_BYTE = 3'd2,
    ACT_RAW_GET  = 3'd3,
    ACT_PKT_GET  = 3'd4,
    ACT_GET_BYTE = 3'd5
  } prf_action_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_REFUSED   = 2'd1,
    STS_TOO_SMALL = 2'd2,
    STS_SEQ_ERR   = 2'd3
  } prf_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR_WR,
    ST_HDR_RD
  } prf_state_e;

endpackage

// ----- rtl/core/prf_if.sv -----
// Item channels of the packet ring FIFO: request channel and result channel.
interface prf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] length;
  logic [7:0]  data_byte;

  modport source (output valid, action, length, data_byte, input ready);
  modport sink   (input valid, action, length, data_byte, output ready);
endinterface

interface prf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  read_byte;
  logic [31:0] packet_length;
  logic        last;

  modport source (output valid, status, read_byte, packet_length, last, input ready);
  modport sink   (input valid, status, read_byte, packet_length, last, output ready);
endinterface

// ----- rtl/core/prf_mem.sv -----
// Byte store: one write port, one registered read port with write-first bypass.
module prf_mem #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/packet_ring_fifo_unit.sv -----
// Packet ring FIFO top level: session control, counters and result register.
//
// Byte ring of DEPTH entries with length-prefixed packet sessions.
// in_i carries one request item (action, length, data_byte); out_o returns
// exactly one result item (status, read_byte, packet_length, last) per request.
// Put byte, get byte, raw put begin and raw get begin each have their result
// registered and visible the cycle after acceptance.
// A packet put begin writes the 4-byte header through the single write
// port of the byte store, one byte per cycle; its result is visible the
// cycle after acceptance; the next item waits until the header is written.
// A packet get begin reads the header through the single read port of the
// byte store, one byte per cycle, and registers its result when the last
// header byte is read.
// The read port is kept aimed at the next read position, so get byte items
// stream out one per cycle while the receiver does not stall.
// Reset clears all counters and sessions; the byte store is not cleared.
// A stalled receiver holds the result register; a new item is taken only
// when that register is empty or is being drained in the same cycle.
module packet_ring_fifo_unit #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  prf_in_if.sink    in_i,
  prf_out_if.source out_o
);

  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned CW    = IW + 1;
  localparam int unsigned CMP_W = ((CW > 17) ? CW : 17) + 1;

  prf_pkg::prf_state_e state_q, state_d;
  logic [1:0]    cnt_q, cnt_d;
  logic [CW-1:0] cwc_q, cwc_d;
  logic [CW-1:0] rc_q, rc_d;
  logic [CW-1:0] pwc_q, pwc_d;
  logic [16:0]   put_left_q, put_left_d;
  logic [16:0]   get_left_q, get_left_d;
  logic          put_open_q, put_open_d;
  logic          get_open_q, get_open_d;
  logic [IW-1:0] wr_ptr_q, wr_ptr_d;
  logic [7:0]    hi_q, hi_d;
  logic [23:0]   hdr_q, hdr_d;
  logic [15:0]   cap_q, cap_d;

  logic          ov_q, ov_d;
  logic [1:0]    status_q, status_d;
  logic [7:0]    rbyte_q, rbyte_d;
  logic [31:0]   plen_q, plen_d;
  logic          last_q, last_d;

  logic          in_ready;
  logic          accept;
  logic          load;
  logic [CW-1:0] stored;
  logic [CW-1:0] free_sp;
  logic [16:0]   need;
  logic [CW-1:0] put_base;
  logic [31:0]   cl;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          rd_hdr;
  logic [IW-1:0] hdr_addr;
  logic [IW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign stored   = cwc_q - rc_q;
  assign free_sp  = CW'(DEPTH) - stored;
  assign in_ready = (state_q == prf_pkg::ST_IDLE) && (!ov_q || out_o.ready);
  assign accept   = in_i.valid && in_ready;
  assign need     = 17'(in_i.length) +
                    ((in_i.action == prf_pkg::ACT_PKT_PUT) ? 17'(prf_pkg::HDR_BYTES) : 17'd0);
  assign put_base = (in_i.action == prf_pkg::ACT_PKT_PUT) ?
                    cwc_q + CW'(prf_pkg::HDR_BYTES) : cwc_q;
  assign cl       = {mem_rdata, hdr_q};

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cwc_d      = cwc_q;
    rc_d       = rc_q;
    pwc_d      = pwc_q;
    put_left_d = put_left_q;
    get_left_d = get_left_q;
    put_open_d = put_open_q;
    get_open_d = get_open_q;
    wr_ptr_d   = wr_ptr_q;
    hi_d       = hi_q;
    hdr_d      = hdr_q;
    cap_d      = cap_q;
    ov_d       = ov_q && !out_o.ready;
    load       = 1'b0;
    status_d   = prf_pkg::STS_OK;
    rbyte_d    = 8'd0;
    plen_d     = 32'd0;
    last_d     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = pwc_q[IW-1:0];
    mem_wdata  = in_i.data_byte;
    rd_hdr     = 1'b0;
    hdr_addr   = rc_q[IW-1:0] + IW'(1);

    case (state_q)
      prf_pkg::ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (prf_pkg::prf_action_e'(in_i.action))
            prf_pkg::ACT_RAW_PUT, prf_pkg::ACT_PKT_PUT: begin
              if (put_open_q) begin
                status_d = prf_pkg::STS_SEQ_ERR;
              end else if (CMP_W'(need) > CMP_W'(free_sp)) begin
                status_d = prf_pkg::STS_REFUSED;
              end else begin
                pwc_d = put_base;
                if (in_i.action == prf_pkg::ACT_PKT_PUT) begin
                  mem_we    = 1'b1;
                  mem_waddr = cwc_q[IW-1:0];
                  mem_wdata = in_i.length[7:0];
                  wr_ptr_d  = cwc_q[IW-1:0] + IW'(1);
                  hi_d      = in_i.length[15:8];
                  cnt_d     = 2'd1;
                  state_d   = prf_pkg::ST_HDR_WR;
                end
                if (in_i.length == 16'd0) begin
                  cwc_d  = put_base;
                  last_d = 1'b1;
                end else begin
                  put_left_d = 17'(in_i.length);
                  put_open_d = 1'b1;
                end
              end
            end
            prf_pkg::ACT_PUT_BYTE: begin
              if (!put_open_q) begin
                status_d = prf_pkg::STS_SEQ_ERR;
              end else begin
                mem_we     = 1'b1;
                pwc_d      = pwc_q + CW'(1);
                put_left_d = put_left_q - 17'd1;
                if (put_left_q == 17'd1) begin
                  cwc_d      = pwc_q + CW'(1);
                  put_open_d = 1'b0;
                  last_d     = 1'b1;
                end
              end
            end
            prf_pkg::ACT_RAW_GET: begin
              if (get_open_q) begin
                status_d = prf_pkg::STS_SEQ_ERR;
              end else if (CMP_W'(stored) < CMP_W'(in_i.length)) begin
                status_d = prf_pkg::STS_REFUSED;
              end else if (in_i.length == 16'd0) begin
                last_d = 1'b1;
              end else begin
                get_left_d = 17'(in_i.length);
                get_open_d = 1'b1;
              end
            end
            prf_pkg::ACT_PKT_GET: begin
              if (get_open_q) begin
                status_d = prf_pkg::STS_SEQ_ERR;
              end else if (CMP_W'(stored) < CMP_W'(prf_pkg::HDR_BYTES)) begin
                status_d = prf_pkg::STS_REFUSED;
              end else begin
                load    = 1'b0;
                hdr_d   = {mem_rdata, hdr_q[23:8]};
                cap_d   = in_i.length;
                cnt_d   = 2'd1;
                rd_hdr  = 1'b1;
                state_d = prf_pkg::ST_HDR_RD;
              end
            end
            prf_pkg::ACT_GET_BYTE: begin
              if (!get_open_q) begin
                status_d = prf_pkg::STS_SEQ_ERR;
              end else begin
                rbyte_d    = mem_rdata;
                rc_d       = rc_q + CW'(1);
                get_left_d = get_left_q - 17'd1;
                if (get_left_q == 17'd1) begin
                  get_open_d = 1'b0;
                  last_d     = 1'b1;
                end
              end
            end
            default: begin
              status_d = prf_pkg::STS_SEQ_ERR;
            end
          endcase
        end
      end
      prf_pkg::ST_HDR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_q;
        mem_wdata = (cnt_q == 2'd1) ? hi_q : 8'd0;
        wr_ptr_d  = wr_ptr_q + IW'(1);
        cnt_d     = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = prf_pkg::ST_IDLE;
        end
      end
      prf_pkg::ST_HDR_RD: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q != 2'd3) begin
          hdr_d    = {mem_rdata, hdr_q[23:8]};
          rd_hdr   = 1'b1;
          hdr_addr = rc_q[IW-1:0] + IW'(cnt_q) + IW'(1);
        end else begin
          load    = 1'b1;
          plen_d  = cl;
          state_d = prf_pkg::ST_IDLE;
          if (32'(stored - CW'(prf_pkg::HDR_BYTES)) < cl) begin
            status_d = prf_pkg::STS_REFUSED;
          end else if (32'(cap_q) < cl) begin
            status_d = prf_pkg::STS_TOO_SMALL;
          end else begin
            rc_d = rc_q + CW'(prf_pkg::HDR_BYTES);
            if (cl == 32'd0) begin
              last_d = 1'b1;
            end else begin
              get_left_d = cl[16:0];
              get_open_d = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = prf_pkg::ST_IDLE;
      end
    endcase

    if (load) begin
      ov_d = 1'b1;
    end
    mem_raddr = rd_hdr ? hdr_addr : rc_d[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= prf_pkg::ST_IDLE;
      cnt_q      <= 2'd0;
      cwc_q      <= '0;
      rc_q       <= '0;
      pwc_q      <= '0;
      put_left_q <= '0;
      get_left_q <= '0;
      put_open_q <= 1'b0;
      get_open_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      cwc_q      <= cwc_d;
      rc_q       <= rc_d;
      pwc_q      <= pwc_d;
      put_left_q <= put_left_d;
      get_left_q <= get_left_d;
      put_open_q <= put_open_d;
      get_open_q <= get_open_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_ptr_q <= wr_ptr_d;
    hi_q     <= hi_d;
    hdr_q    <= hdr_d;
    cap_q    <= cap_d;
    if (load) begin
      status_q <= status_d;
      rbyte_q  <= rbyte_d;
      plen_q   <= plen_d;
      last_q   <= last_d;
    end
  end

  prf_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (mem_we),
    .wr_addr_i(mem_waddr),
    .wr_data_i(mem_wdata),
    .rd_addr_i(mem_raddr),
    .rd_data_o(mem_rdata)
  );

  assign in_i.ready          = in_ready;
  assign out_o.valid         = ov_q;
  assign out_o.status        = status_q;
  assign out_o.read_byte     = rbyte_q;
  assign out_o.packet_length = plen_q;
  assign out_o.last          = last_q;

`ifndef SYNTHESIS
  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(stored) <= CMP_W'(DEPTH))
    else $error("stored byte count exceeds ring depth");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    put_open_q |-> CMP_W'(pwc_q - rc_q) <= CMP_W'(DEPTH))
    else $error("pending writes overrun unread data");

  a_get_covered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    get_open_q |-> (get_left_q != 17'd0) && (CMP_W'(get_left_q) <= CMP_W'(stored)))
    else $error("open get session exceeds stored bytes");

  a_hdr_rd_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.action == prf_pkg::ACT_PKT_GET) && !get_open_q &&
     (CMP_W'(stored) >= CMP_W'(prf_pkg::HDR_BYTES))) |=> (state_q == prf_pkg::ST_HDR_RD))
    else $error("packet get did not start header read");
`endif

endmodule

// ----- verif/tb.sv -----
// Testbench for packet_ring_fifo_unit: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned TIMEOUT_NS = 30_000_000;
  localparam logic [2:0] ACT_BAD_6 = 3'd6;
  localparam logic [2:0] ACT_BAD_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] length;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [31:0] packet_length;
    logic        last;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  prf_in_if  req_if ();
  prf_out_if reply_if ();

  packet_ring_fifo_unit #(.DEPTH(RING_DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (reply_if)
  );

  logic [7:0]       ring_mem [RING_DEPTH];
  logic [CNT_W-1:0] wr_commit = '0;
  logic [CNT_W-1:0] wr_pend = '0;
  logic [CNT_W-1:0] rd_cnt = '0;
  logic [16:0]      put_left = '0;
  logic [16:0]      get_left = '0;
  logic             put_busy = 1'b0;
  logic             get_busy = 1'b0;

  req_t        req_backlog[$];
  req_t        put_side[$];
  req_t        get_side[$];
  reply_t      due_replies[$];
  int unsigned reqs_queued;
  int unsigned reqs_taken;
  int unsigned replies_owed;
  int unsigned err_cnt;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned phase_cnt;
  bit          calm_in;
  bit          calm_out;
  bit          req_taken;

  function automatic int unsigned fill_level();
    logic [CNT_W-1:0] diff;
    diff = wr_commit - rd_cnt;
    return int'(diff);
  endfunction

  function automatic int unsigned space_left();
    int unsigned used;
    used = fill_level();
    return (used >= RING_DEPTH) ? 0 : RING_DEPTH - used;
  endfunction

  function automatic logic [31:0] head_word();
    logic [IDX_W-1:0] idx;
    logic [31:0]      word;
    for (int k = 0; k < prf_pkg::HDR_BYTES; k++) begin
      idx = rd_cnt[IDX_W-1:0] + IDX_W'(k);
      word[8*k +: 8] = ring_mem[idx];
    end
    return word;
  endfunction

  function automatic void store_pending(logic [7:0] b);
    ring_mem[wr_pend[IDX_W-1:0]] = b;
    wr_pend = wr_pend + CNT_W'(1);
  endfunction

  function automatic reply_t ring_apply(req_t r);
    reply_t      rp;
    int unsigned need;
    int unsigned have;
    logic [31:0] word;
    rp = '0;
    case (r.action)
      prf_pkg::ACT_RAW_PUT, prf_pkg::ACT_PKT_PUT: begin
        need = r.length + ((r.action == prf_pkg::ACT_PKT_PUT) ? prf_pkg::HDR_BYTES : 0);
        if (put_busy) rp.status = prf_pkg::STS_SEQ_ERR;
        else if (need > space_left()) rp.status = prf_pkg::STS_REFUSED;
        else begin
          wr_pend = wr_commit;
          if (r.action == prf_pkg::ACT_PKT_PUT) begin
            store_pending(r.length[7:0]);
            store_pending(r.length[15:8]);
            store_pending(8'h00);
            store_pending(8'h00);
          end
          if (r.length == 0) begin
            wr_commit = wr_pend;
            rp.last = 1'b1;
          end else begin
            put_left = 17'(r.length);
            put_busy = 1'b1;
          end
        end
      end
      prf_pkg::ACT_PUT_BYTE: begin
        if (!put_busy) rp.status = prf_pkg::STS_SEQ_ERR;
        else begin
          store_pending(r.data_byte);
          put_left = put_left - 17'd1;
          if (put_left == 0) begin
            wr_commit = wr_pend;
            put_busy = 1'b0;
            rp.last = 1'b1;
          end
        end
      end
      prf_pkg::ACT_RAW_GET: begin
        if (get_busy) rp.status = prf_pkg::STS_SEQ_ERR;
        else if (fill_level() < r.length) rp.status = prf_pkg::STS_REFUSED;
        else if (r.length == 0) rp.last = 1'b1;
        else begin
          get_left = 17'(r.length);
          get_busy = 1'b1;
        end
      end
      prf_pkg::ACT_PKT_GET: begin
        have = fill_level();
        if (get_busy) rp.status = prf_pkg::STS_SEQ_ERR;
        else if (have < prf_pkg::HDR_BYTES) rp.status = prf_pkg::STS_REFUSED;
        else begin
          word = head_word();
          rp.packet_length = word;
          if (have - prf_pkg::HDR_BYTES < word) rp.status = prf_pkg::STS_REFUSED;
          else if (r.length < word) rp.status = prf_pkg::STS_TOO_SMALL;
          else begin
            rd_cnt = rd_cnt + CNT_W'(prf_pkg::HDR_BYTES);
            if (word == 0) rp.last = 1'b1;
            else begin
              get_left = word[16:0];
              get_busy = 1'b1;
            end
          end
        end
      end
      prf_pkg::ACT_GET_BYTE: begin
        if (!get_busy) rp.status = prf_pkg::STS_SEQ_ERR;
        else begin
          rp.read_byte = ring_mem[rd_cnt[IDX_W-1:0]];
          rd_cnt = rd_cnt + CNT_W'(1);
          get_left = get_left - 17'd1;
          if (get_left == 0) begin
            get_busy = 1'b0;
            rp.last = 1'b1;
          end
        end
      end
      default: rp.status = prf_pkg::STS_SEQ_ERR;
    endcase
    return rp;
  endfunction

  function automatic req_t mk_req(logic [2:0] act, int unsigned len, int unsigned dat);
    return {act, len[15:0], dat[7:0]};
  endfunction

  function automatic void post(req_t r);
    req_backlog.push_back(r);
    reqs_queued++;
  endfunction

  function automatic void flag_error(string msg);
    if (err_cnt < MAX_REPORTS) $display("ERROR: %s", msg);
    err_cnt++;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 12);
    if (r < 96) return $urandom_range(13, 64);
    if (r < 99) return $urandom_range(65, 600);
    return $urandom_range(0, 65535);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb failed");
    $finish;
  end

  always @(negedge clk_i) begin : drive_blk
    req_t nxt;
    logic v;
    logic rdy;
    phase_cnt++;
    if (phase_cnt % 256 == 0) begin
      calm_in = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
    end
    v = req_if.valid;
    if (!rst_ni) v = 1'b0;
    else begin
      if (req_taken) begin
        v = 1'b0;
        req_taken = 1'b0;
      end
      if (!v) begin
        if (gap_left > 0) gap_left--;
        else if (req_backlog.size() > 0) begin
          nxt = req_backlog.pop_front();
          req_if.action <= nxt.action;
          req_if.length <= nxt.length;
          req_if.data_byte <= nxt.data_byte;
          v = 1'b1;
          gap_left = calm_in ? 0 : pick_gap();
        end
      end
    end
    req_if.valid <= v;
    if (stall_left > 0) begin
      rdy = 1'b0;
      stall_left--;
    end else begin
      rdy = 1'b1;
      stall_left = calm_out ? 0 : pick_gap();
    end
    reply_if.ready <= rdy;
  end

  always @(posedge clk_i) begin : check_blk
    reply_t got;
    reply_t want;
    if (rst_ni) begin
      if (reply_if.valid && reply_if.ready) begin
        got = {reply_if.status, reply_if.read_byte, reply_if.packet_length, reply_if.last};
        if (replies_owed == 0) begin
          flag_error($sformatf("reply with no request pending: sts=%0d byte=%02h len=%0d last=%0b",
                               got.status, got.read_byte, got.packet_length, got.last));
        end else begin
          want = due_replies.pop_front();
          replies_owed--;
          if (got !== want) begin
            flag_error($sformatf({"mismatch: exp sts=%0d byte=%02h len=%0d last=%0b, ",
                                  "got sts=%0d byte=%02h len=%0d last=%0b"},
                                 want.status, want.read_byte, want.packet_length, want.last,
                                 got.status, got.read_byte, got.packet_length, got.last));
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        due_replies.push_back(ring_apply({req_if.action, req_if.length, req_if.data_byte}));
        replies_owed++;
        reqs_taken++;
        req_taken = 1'b1;
      end
    end
  end

  initial begin : stimulus_blk
    int unsigned r;
    int unsigned len;
    int unsigned n;
    int unsigned have;
    int unsigned cap;
    int unsigned claim;
    int unsigned target;
    logic [31:0] word;
    bit          pkt_ok;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = prf_pkg::ACT_RAW_PUT;
    req_if.length = '0;
    req_if.data_byte = '0;
    reply_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    post(mk_req(prf_pkg::ACT_GET_BYTE, 0, 0));
    post(mk_req(ACT_BAD_7, 16'hFFFF, 8'hFF));
    post(mk_req(prf_pkg::ACT_PKT_GET, 0, 0));
    post(mk_req(prf_pkg::ACT_RAW_GET, 0, 0));
    post(mk_req(prf_pkg::ACT_RAW_PUT, 0, 0));
    post(mk_req(prf_pkg::ACT_RAW_PUT, 16'hFFFF, 0));
    post(mk_req(prf_pkg::ACT_PKT_PUT, RING_DEPTH - prf_pkg::HDR_BYTES + 1, 0));
    post(mk_req(prf_pkg::ACT_PKT_PUT, 0, 0));
    post(mk_req(prf_pkg::ACT_PKT_GET, 0, 0));
    post(mk_req(prf_pkg::ACT_PKT_PUT, 2, 0));
    post(mk_req(prf_pkg::ACT_RAW_PUT, 1, 0));
    post(mk_req(prf_pkg::ACT_PUT_BYTE, 0, 8'hFF));
    post(mk_req(prf_pkg::ACT_PUT_BYTE, 0, 8'h00));
    post(mk_req(prf_pkg::ACT_PKT_GET, 1, 0));
    post(mk_req(prf_pkg::ACT_PKT_GET, 2, 0));
    post(mk_req(prf_pkg::ACT_RAW_GET, 1, 0));
    post(mk_req(prf_pkg::ACT_GET_BYTE, 0, 0));
    post(mk_req(prf_pkg::ACT_GET_BYTE, 0, 0));
    post(mk_req(prf_pkg::ACT_RAW_PUT, 5, 0));
    post(mk_req(prf_pkg::ACT_PUT_BYTE, 0, 8'h05));
    post(mk_req(prf_pkg::ACT_PUT_BYTE, 0, 8'h00));
    post(mk_req(prf_pkg::ACT_PUT_BYTE, 0, 8'h00));
    post(mk_req(prf_pkg::ACT_PUT_BYTE, 0, 8'h00));
    post(mk_req(prf_pkg::ACT_PUT_BYTE, 0, 8'hAA));
    post(mk_req(prf_pkg::ACT_PKT_GET, 16'hFFFF, 0));
    post(mk_req(prf_pkg::ACT_RAW_GET, 6, 0));

    target = reqs_queued + RANDOM_ITEMS;
    while (reqs_queued < target) begin
      wait (reqs_taken == reqs_queued);

      n = 0;
      if (put_busy) begin
        if ($urandom_range(0, 9) == 0) begin
          put_side.push_back(mk_req(prf_pkg::ACT_PKT_PUT, pick_len(), 0));
        end
        n = put_left;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          len = pick_len();
          put_side.push_back(mk_req(prf_pkg::ACT_PKT_PUT, len, 0));
          if (len + prf_pkg::HDR_BYTES <= space_left()) n = len;
        end else if (r < 57) begin
          // raw put that forges a packet header, sound or broken
          len = $urandom_range(prf_pkg::HDR_BYTES, 24);
          r = $urandom_range(0, 9);
          claim = (r < 4) ? len - prf_pkg::HDR_BYTES : (r < 7) ? $urandom_range(0, 30) : $urandom();
          put_side.push_back(mk_req(prf_pkg::ACT_RAW_PUT, len, 0));
          for (int k = 0; k < prf_pkg::HDR_BYTES; k++) begin
            put_side.push_back(mk_req(prf_pkg::ACT_PUT_BYTE, 0, claim >> (8 * k)));
          end
          n = len - prf_pkg::HDR_BYTES;
        end else if (r < 75) begin
          len = pick_len();
          put_side.push_back(mk_req(prf_pkg::ACT_RAW_PUT, len, 0));
          if (len <= space_left()) n = len;
        end
      end
      if (n > 0 && $urandom_range(0, 19) == 0) n = $urandom_range(0, n - 1);
      repeat (n) put_side.push_back(mk_req(prf_pkg::ACT_PUT_BYTE, 0, $urandom_range(0, 255)));
      if (n == 0 && $urandom_range(0, 9) == 0) begin
        put_side.push_back(mk_req(prf_pkg::ACT_PUT_BYTE, 0, $urandom_range(0, 255)));
      end
      if ($urandom_range(0, 24) == 0) begin
        put_side.push_back(mk_req($urandom_range(0, 1) ? ACT_BAD_6 : ACT_BAD_7,
                                  $urandom(), $urandom()));
      end

      n = 0;
      if (get_busy) begin
        if ($urandom_range(0, 9) == 0) begin
          get_side.push_back(mk_req(prf_pkg::ACT_PKT_GET, 16'hFFFF, 0));
        end
        n = get_left;
      end else begin
        have = fill_level();
        pkt_ok = 1'b0;
        word = '0;
        if (have >= prf_pkg::HDR_BYTES) begin
          word = head_word();
          pkt_ok = (have - prf_pkg::HDR_BYTES >= word);
        end
        r = $urandom_range(0, 99);
        if (have >= prf_pkg::HDR_BYTES && !pkt_ok && r < 55 && $urandom_range(0, 1) == 0) r = 60;
        if (r < 55) begin
          if (!pkt_ok) cap = $urandom_range(0, 65535);
          else if (word > 0 && $urandom_range(0, 7) == 0) cap = $urandom_range(0, word - 1);
          else if ($urandom_range(0, 3) == 0) cap = 65535;
          else cap = word + $urandom_range(0, 20);
          get_side.push_back(mk_req(prf_pkg::ACT_PKT_GET, cap, 0));
          if (pkt_ok && cap >= word) n = word;
        end else if (r < 85) begin
          if (have == 0 || $urandom_range(0, 7) == 0) len = $urandom_range(have + 1, 65535);
          else len = $urandom_range(1, have);
          get_side.push_back(mk_req(prf_pkg::ACT_RAW_GET, len, 0));
          if (len <= have) n = len;
        end
      end
      if (n > 0 && $urandom_range(0, 19) == 0) n = $urandom_range(0, n - 1);
      repeat (n) get_side.push_back(mk_req(prf_pkg::ACT_GET_BYTE, 0, $urandom_range(0, 255)));
      if (n == 0 && $urandom_range(0, 9) == 0) begin
        get_side.push_back(mk_req(prf_pkg::ACT_GET_BYTE, 0, 0));
      end

      // lead with the get item so its outcome matches the ring as planned
      if (get_side.size() > 0) post(get_side.pop_front());
      while (put_side.size() + get_side.size() > 0) begin
        if (get_side.size() == 0 || (put_side.size() > 0 && $urandom_range(0, 1) == 0)) begin
          post(put_side.pop_front());
        end else begin
          post(get_side.pop_front());
        end
      end
    end

    wait (reqs_taken == reqs_queued);
    wait (replies_owed == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/prf_pkg.sv
rtl/core/prf_if.sv
rtl/core/prf_mem.sv
rtl/core/packet_ring_fifo_unit.sv
verif/tb.sv
